### src/clc_pkg.sv
// ----------------------------------------------------------------------------
// clc_pkg
// Shared constants and controller/datapath interface types for the
// collinear line counter.
// ----------------------------------------------------------------------------
package clc_pkg;

  localparam int KMIN_W      = 9;
  localparam logic [KMIN_W-1:0] KMIN_RESET = 9'd2;
  localparam int LINE_W      = 15;
  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic store;
    logic close;
    logic clr;
    logic rd_i;
    logic rd_j;
    logic ld_j;
    logic sweep;
    logic hist_rd;
    logic hist_wr;
    logic sum_rd;
    logic div_start;
    logic sum_acc;
    logic res_load;
  } clc_cmd_t;

  typedef struct packed {
    logic k_inf;
    logic clr_last;
    logic pair_ok;
    logic k_last;
    logic pipe_busy;
    logic sum_ok;
    logic div_busy;
    logic out_free;
  } clc_sts_t;

endpackage

### src/clc_div.sv
// ----------------------------------------------------------------------------
// clc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clc_div #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W+1:0]  diff;

  assign diff = {1'b0, rem_r, quo_r[W-1]} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (!diff[W+1]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[W-2:0], quo_r[W-1]};
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### src/clc_dp.sv
// ----------------------------------------------------------------------------
// clc_dp
// Datapath: point store, cross-product pipeline, pair histogram, per-bin
// division and summation, result register.
// ----------------------------------------------------------------------------
module clc_dp import clc_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [KMIN_W-1:0]     cfg_wr_data,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  clc_cmd_t              cmd,
  output clc_sts_t              sts,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [LINE_W-1:0]     line_count,
  output logic                  infinite
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int PCNT_W = $clog2(MAX_POINTS + 1);
  localparam int J_W    = $clog2(MAX_POINTS + 2);
  localparam int SK_W   = (KMIN_W > J_W) ? KMIN_W : J_W;
  localparam int PAIRS  = MAX_POINTS * (MAX_POINTS - 1) / 2;
  localparam int HIST_W = ($clog2(PAIRS + 1) > 2) ? $clog2(PAIRS + 1) : 2;
  localparam int HDEPTH = MAX_POINTS + 1;
  localparam int DW     = COORD_BITS + 1;
  localparam int PW     = 2 * DW;

  logic [KMIN_W-1:0] kmin_r;
  logic [PCNT_W-1:0] n_r;
  logic [IDX_W-1:0]  i_r;
  logic [J_W-1:0]    j_r;
  logic [IDX_W-1:0]  k_r;
  logic [PCNT_W-1:0] c_r;
  logic [PCNT_W-1:0] cnt_r;
  logic [SK_W-1:0]   sk_r;
  logic [HIST_W-1:0] total_r;
  logic              inf_r;
  logic [HIST_W-1:0] div_r;

  logic [COORD_BITS-1:0] px_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] py_mem [MAX_POINTS];
  logic [COORD_BITS-1:0] rd_x_r, rd_y_r;
  logic [COORD_BITS-1:0] pi_x_r, pi_y_r, pj_x_r, pj_y_r;

  logic              vld1_r, vld2_r, vld3_r;
  logic              skip1_r, skip2_r, skip3_r;
  logic signed [DW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [PW-1:0] p1_r, p2_r;

  logic [HIST_W-1:0] hist_mem [HDEPTH];
  logic [HIST_W-1:0] hist_rd_r;

  logic              out_vld_r;
  logic [LINE_W-1:0] line_r;
  logic              inf_out_r;

  logic              full;
  logic              pt_ren;
  logic [IDX_W-1:0]  pt_raddr;
  logic              h_we;
  logic              h_re;
  logic [PCNT_W-1:0] h_waddr;
  logic [PCNT_W-1:0] h_raddr;
  logic [HIST_W-1:0] h_wdata;
  logic [SK_W-1:0]   kstart;
  logic [PCNT_W-1:0] sk_c;
  logic [2*PCNT_W-1:0] tri_prod;
  logic              div_busy;
  logic [HIST_W-1:0] quo;
  logic signed [DW-1:0] ix, iy, jx, jy, kx, ky;

  assign full     = (n_r >= PCNT_W'(MAX_POINTS));
  assign pt_ren   = cmd.rd_i | cmd.rd_j | cmd.sweep;
  assign pt_raddr = cmd.rd_i ? i_r : (cmd.rd_j ? j_r[IDX_W-1:0] : k_r);
  assign kstart   = (kmin_r < KMIN_W'(2)) ? SK_W'(2) : SK_W'(kmin_r);
  assign sk_c     = sk_r[PCNT_W-1:0];
  assign tri_prod = (2*PCNT_W)'(sk_c) * (2*PCNT_W)'(sk_c - 1'b1);

  assign h_we    = cmd.clr | cmd.hist_wr;
  assign h_re    = cmd.hist_rd | cmd.sum_rd;
  assign h_waddr = cmd.clr ? c_r : cnt_r;
  assign h_raddr = cmd.sum_rd ? sk_c : cnt_r;
  assign h_wdata = cmd.clr ? '0 : hist_rd_r + 1'b1;

  assign ix = $signed({pi_x_r[COORD_BITS-1], pi_x_r});
  assign iy = $signed({pi_y_r[COORD_BITS-1], pi_y_r});
  assign jx = $signed({pj_x_r[COORD_BITS-1], pj_x_r});
  assign jy = $signed({pj_y_r[COORD_BITS-1], pj_y_r});
  assign kx = $signed({rd_x_r[COORD_BITS-1], rd_x_r});
  assign ky = $signed({rd_y_r[COORD_BITS-1], rd_y_r});

  // point store
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      px_mem[n_r[IDX_W-1:0]] <= px;
      py_mem[n_r[IDX_W-1:0]] <= py;
    end
    if (pt_ren) begin
      rd_x_r <= px_mem[pt_raddr];
      rd_y_r <= py_mem[pt_raddr];
    end
  end

  // pair histogram
  always_ff @(posedge clk) begin
    if (h_we) begin
      hist_mem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      hist_rd_r <= hist_mem[h_raddr];
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmin_r    <= KMIN_RESET;
      n_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      c_r       <= '0;
      sk_r      <= '0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      vld3_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kmin_r <= cfg_wr_data;
      end
      if (cmd.res_load) begin
        n_r <= '0;
      end else if (cmd.store && !full) begin
        n_r <= n_r + 1'b1;
      end
      if (cmd.close) begin
        c_r  <= '0;
        i_r  <= '0;
        j_r  <= J_W'(1);
        sk_r <= kstart;
      end
      if (cmd.clr) begin
        c_r <= c_r + 1'b1;
      end
      if (cmd.ld_j) begin
        k_r <= '0;
      end else if (cmd.sweep) begin
        k_r <= k_r + 1'b1;
      end
      if (cmd.hist_wr) begin
        if (j_r + 1'b1 < J_W'(n_r)) begin
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          j_r <= J_W'(i_r) + J_W'(2);
        end
      end
      if (cmd.sum_acc) begin
        sk_r <= sk_r + 1'b1;
      end
      vld1_r <= cmd.sweep;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      if (cmd.res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.close) begin
      total_r <= '0;
      inf_r   <= (kmin_r < KMIN_W'(2));
    end else if (cmd.sum_acc) begin
      total_r <= total_r + quo;
    end
    if (cmd.rd_j) begin
      pi_x_r <= rd_x_r;
      pi_y_r <= rd_y_r;
    end
    if (cmd.ld_j) begin
      pj_x_r <= rd_x_r;
      pj_y_r <= rd_y_r;
    end
    if (cmd.rd_i) begin
      cnt_r <= PCNT_W'(2);
    end else if (vld3_r && !skip3_r && (p1_r == p2_r)) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.sum_rd) begin
      div_r <= HIST_W'(tri_prod >> 1);
    end
    skip1_r <= (k_r == i_r) || (J_W'(k_r) == j_r);
    skip2_r <= skip1_r;
    skip3_r <= skip2_r;
    x1_r    <= ix - kx;
    y1_r    <= iy - ky;
    x2_r    <= jx - kx;
    y2_r    <= jy - ky;
    p1_r    <= x1_r * y2_r;
    p2_r    <= x2_r * y1_r;
    if (cmd.res_load) begin
      line_r    <= LINE_W'(total_r);
      inf_out_r <= inf_r;
    end
  end

  clc_div #(
    .W(HIST_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (hist_rd_r),
    .divisor  (div_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    sts.k_inf     = (kmin_r < KMIN_W'(2));
    sts.clr_last  = (c_r == PCNT_W'(MAX_POINTS));
    sts.pair_ok   = (j_r < J_W'(n_r));
    sts.k_last    = ((PCNT_W'(k_r) + PCNT_W'(1)) == n_r);
    sts.pipe_busy = vld1_r | vld2_r | vld3_r;
    sts.sum_ok    = (sk_r <= SK_W'(n_r));
    sts.div_busy  = div_busy;
    sts.out_free  = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign line_count = line_r;
  assign infinite   = inf_out_r;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_wr |-> (cnt_r <= n_r) && (cnt_r >= PCNT_W'(2)))
    else $error("collinear count outside 2..n");
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> (div_r != '0))
    else $error("zero divisor at divider start");
  a_n_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= PCNT_W'(MAX_POINTS))
    else $error("point count above capacity");
  a_res_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !vld1_r && !vld2_r && !vld3_r && !div_busy)
    else $error("result loaded while work in flight");
`endif

endmodule

### src/clc_ctrl.sv
// ----------------------------------------------------------------------------
// clc_ctrl
// Sequencer: point loading, histogram clear, pair sweep, per-bin sum and
// result handoff.
// ----------------------------------------------------------------------------
module clc_ctrl import clc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  clc_sts_t sts,
  output clc_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_LOAD     = 13'b0000000000001,
    S_CLEAR    = 13'b0000000000010,
    S_PAIR_I   = 13'b0000000000100,
    S_PAIR_J   = 13'b0000000001000,
    S_LATCH_J  = 13'b0000000010000,
    S_SWEEP    = 13'b0000000100000,
    S_DRAIN    = 13'b0000001000000,
    S_HIST_RD  = 13'b0000010000000,
    S_HIST_WR  = 13'b0000100000000,
    S_SUM_RD   = 13'b0001000000000,
    S_SUM_DIV  = 13'b0010000000000,
    S_SUM_WAIT = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.store = 1'b1;
          if (in_tlast) begin
            cmd.close = 1'b1;
            state_nxt = sts.k_inf ? S_DONE : S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_PAIR_I;
        end
      end
      S_PAIR_I: begin
        if (sts.pair_ok) begin
          cmd.rd_i  = 1'b1;
          state_nxt = S_PAIR_J;
        end else begin
          state_nxt = S_SUM_RD;
        end
      end
      S_PAIR_J: begin
        cmd.rd_j  = 1'b1;
        state_nxt = S_LATCH_J;
      end
      S_LATCH_J: begin
        cmd.ld_j  = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_HIST_RD;
        end
      end
      S_HIST_RD: begin
        cmd.hist_rd = 1'b1;
        state_nxt   = S_HIST_WR;
      end
      S_HIST_WR: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = S_PAIR_I;
      end
      S_SUM_RD: begin
        if (sts.sum_ok) begin
          cmd.sum_rd = 1'b1;
          state_nxt  = S_SUM_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SUM_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_SUM_WAIT;
      end
      S_SUM_WAIT: begin
        if (!sts.div_busy) begin
          cmd.sum_acc = 1'b1;
          state_nxt   = S_SUM_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

### src/collinear_line_counter.sv
// ----------------------------------------------------------------------------
// collinear_line_counter
// Counts distinct lines through at least k_min points of a loaded point set.
//
//   channel  dir  payload                                   handshake
//   in_      in   tdata {py, px}, tlast = last point        tvalid/tready
//   out_     out  tdata {0, line_count}, tuser = infinite   tvalid/tready
//   cfg_     in   wr_data = k_min                           wr_en
//
// Points load at one word per cycle. After the last point, the histogram
// is cleared, every pair is swept against all n points through the
// single read port of the point store, and bins k_min..n are divided and
// summed; k_min < 2 skips this and reports infinite. in_tready stays low
// until the result is handed to the output register. Reset is synchronous,
// active low; an output word stalled by out_tready holds its value.
// ----------------------------------------------------------------------------
module collinear_line_counter import clc_pkg::*; #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16,
  localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [KMIN_W-1:0]      cfg_wr_data,   // k_min
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // px, py
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // line_count
  output logic                   out_tuser      // infinite
);

  clc_cmd_t          cmd;
  clc_sts_t          sts;
  logic [LINE_W-1:0] line_count;

  clc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  clc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .px          (in_tdata[COORD_BITS-1:0]),
    .py          (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cmd         (cmd),
    .sts         (sts),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .line_count  (line_count),
    .infinite    (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W - LINE_W){1'b0}}, line_count};

endmodule
